// ===== hw/rtl/ycs_pkg.sv =====
// ---------------------------------------------------------------------------
// ycs_pkg
// Shared types, swap codes and defaults for the YCbCr to RGB swap core.
// ---------------------------------------------------------------------------
package ycs_pkg;

  // default number of fraction bits in the coefficients
  localparam int FRAC_BITS_DEF = 16;

  // channel routing codes, named by (red, green, blue) output order
  localparam logic [2:0] SWAP_RBG  = 3'd0;
  localparam logic [2:0] SWAP_BRG  = 3'd1;
  localparam logic [2:0] SWAP_BGR  = 3'd2;
  localparam logic [2:0] SWAP_GRB  = 3'd3;
  localparam logic [2:0] SWAP_GBR  = 3'd4;
  localparam logic [2:0] SWAP_NONE = 3'd5;
  localparam logic [2:0] SWAP_NONE_ALT1 = 3'd6;
  localparam logic [2:0] SWAP_NONE_ALT2 = 3'd7;

  // input pixel beat
  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
  } in_beat_t;

  // output pixel beat
  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } out_beat_t;

  // clamped rgb between the clamp stage and the swap stage
  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

endpackage

// ===== hw/rtl/ycs_mult.sv =====
// ---------------------------------------------------------------------------
// ycs_mult
// Two stages: center the chroma samples, then form the four coefficient
// products and the scaled luma.
// ---------------------------------------------------------------------------
module ycs_mult import ycs_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int PROD_W    = FRAC_BITS + 11
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_vld,
  input  in_beat_t                 in_beat,
  output logic                     out_vld,
  output logic signed [PROD_W-1:0] ys,
  output logic signed [PROD_W-1:0] prod_r,
  output logic signed [PROD_W-1:0] prod_gb,
  output logic signed [PROD_W-1:0] prod_gr,
  output logic signed [PROD_W-1:0] prod_b
);

  // coefficients: round half up of c * 2^FRAC_BITS
  localparam int  COEF_W = FRAC_BITS + 2;
  localparam longint CoefR  = ((longint'(1402)  << FRAC_BITS) + 500)   / 1000;
  localparam longint CoefGb = ((longint'(34414) << FRAC_BITS) + 50000) / 100000;
  localparam longint CoefGr = ((longint'(71414) << FRAC_BITS) + 50000) / 100000;
  localparam longint CoefB  = ((longint'(1772)  << FRAC_BITS) + 500)   / 1000;

  localparam logic signed [COEF_W-1:0] C_R  = COEF_W'(CoefR);
  localparam logic signed [COEF_W-1:0] C_GB = COEF_W'(CoefGb);
  localparam logic signed [COEF_W-1:0] C_GR = COEF_W'(CoefGr);
  localparam logic signed [COEF_W-1:0] C_B  = COEF_W'(CoefB);

  logic              vld1_r;
  logic [7:0]        luma1_r;
  logic signed [8:0] db1_r, dr1_r;
  logic              vld2_r;

  // stage 1: register luma and centered chroma
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
    end
    luma1_r <= in_beat.luma;
    db1_r   <= $signed({1'b0, in_beat.chroma_blue}) - 9'sd128;
    dr1_r   <= $signed({1'b0, in_beat.chroma_red}) - 9'sd128;
  end

  // stage 2: coefficient products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else begin
      vld2_r <= vld1_r;
    end
    ys      <= $signed({{(PROD_W-8-FRAC_BITS){1'b0}}, luma1_r, {FRAC_BITS{1'b0}}});
    prod_r  <= PROD_W'(C_R  * dr1_r);
    prod_gb <= PROD_W'(C_GB * db1_r);
    prod_gr <= PROD_W'(C_GR * dr1_r);
    prod_b  <= PROD_W'(C_B  * db1_r);
  end

  assign out_vld = vld2_r;

endmodule

// ===== hw/rtl/ycs_sum_clamp.sv =====
// ---------------------------------------------------------------------------
// ycs_sum_clamp
// Two stages: add the products per channel, then floor shift and saturate
// each channel to 0..255.
// ---------------------------------------------------------------------------
module ycs_sum_clamp import ycs_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int PROD_W    = FRAC_BITS + 11
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_vld,
  input  logic signed [PROD_W-1:0] ys,
  input  logic signed [PROD_W-1:0] prod_r,
  input  logic signed [PROD_W-1:0] prod_gb,
  input  logic signed [PROD_W-1:0] prod_gr,
  input  logic signed [PROD_W-1:0] prod_b,
  output logic                     out_vld,
  output rgb_t                     rgb
);

  localparam int WHOLE_W = PROD_W - FRAC_BITS;

  logic                     vld3_r, vld4_r;
  logic signed [PROD_W-1:0] sum_r_r, sum_g_r, sum_b_r;
  rgb_t                     rgb_r;

  // saturate the integer part of a channel sum
  function automatic logic [7:0] sat8(input logic signed [PROD_W-1:0] s);
    logic [WHOLE_W-1:0] whole;
    whole = s[PROD_W-1:FRAC_BITS];
    if (whole[WHOLE_W-1]) begin
      sat8 = 8'd0;
    end else if (|whole[WHOLE_W-2:8]) begin
      sat8 = 8'd255;
    end else begin
      sat8 = whole[7:0];
    end
  endfunction

  // stage 3: channel sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end else begin
      vld3_r <= in_vld;
    end
    sum_r_r <= ys + prod_r;
    sum_g_r <= ys - prod_gb - prod_gr;
    sum_b_r <= ys + prod_b;
  end

  // stage 4: floor and clamp
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld4_r <= 1'b0;
    end else begin
      vld4_r <= vld3_r;
    end
    rgb_r.r <= sat8(sum_r_r);
    rgb_r.g <= sat8(sum_g_r);
    rgb_r.b <= sat8(sum_b_r);
  end

  assign out_vld = vld4_r;
  assign rgb     = rgb_r;

endmodule

// ===== hw/rtl/ycs_swap.sv =====
// ---------------------------------------------------------------------------
// ycs_swap
// Output stage: routes the clamped channels per swap mode into the output
// register.
// ---------------------------------------------------------------------------
module ycs_swap import ycs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_vld,
  input  rgb_t       rgb,
  input  logic [2:0] swap_mode,
  output logic       out_vld,
  output out_beat_t  out_beat
);

  logic      vld_r;
  out_beat_t beat_r, beat_nxt;

  // channel routing decode
  always_comb begin
    unique case (swap_mode)
      SWAP_RBG: beat_nxt = '{red_out: rgb.r, green_out: rgb.b, blue_out: rgb.g};
      SWAP_BRG: beat_nxt = '{red_out: rgb.b, green_out: rgb.r, blue_out: rgb.g};
      SWAP_BGR: beat_nxt = '{red_out: rgb.b, green_out: rgb.g, blue_out: rgb.r};
      SWAP_GRB: beat_nxt = '{red_out: rgb.g, green_out: rgb.r, blue_out: rgb.b};
      SWAP_GBR: beat_nxt = '{red_out: rgb.g, green_out: rgb.b, blue_out: rgb.r};
      default:  beat_nxt = '{red_out: rgb.r, green_out: rgb.g, blue_out: rgb.b};
    endcase
  end

  // stage 5: output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
    beat_r <= beat_nxt;
  end

  assign out_vld  = vld_r;
  assign out_beat = beat_r;

endmodule

// ===== hw/rtl/ycbcr_to_rgb_channel_swap_core.sv =====
// ---------------------------------------------------------------------------
// ycbcr_to_rgb_channel_swap_core
// Full-range BT.601 YCbCr to RGB conversion with a channel routing stage.
// ---------------------------------------------------------------------------
// Usage:
//   Pixels enter on in_data as Y, Cb, Cr; a beat is taken at each clock
//   edge with start high. busy is tied low: the core takes one pixel every
//   cycle, back to back, with no gaps needed.
//   Each result is shown on out_data for exactly one cycle with out_valid
//   high, after its input beat has passed the five register stages (center,
//   multiply, sum, clamp, route). Throughput is one pixel per clock, set by
//   the fully pipelined multiply and add stages.
//   The receiver cannot stall, so no result is ever held or dropped.
//   swap_mode is written through cfg_valid/cfg_data; cfg_ready is always
//   high. Write it only while no pixel is in flight.
//   Reset (rst_n low, synchronous) clears all stage valid bits and sets
//   swap_mode to straight through; pixels in flight are discarded.
// ---------------------------------------------------------------------------
module ycbcr_to_rgb_channel_swap_core import ycs_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_beat_t  in_data,
  output logic      out_valid,
  output out_beat_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [2:0] cfg_data
);

  localparam int PROD_W = FRAC_BITS + 11;

  logic                     in_acc;
  logic [2:0]               swap_mode_r;
  logic                     mult_vld, clamp_vld;
  logic signed [PROD_W-1:0] ys, prod_r, prod_gb, prod_gr, prod_b;
  rgb_t                     rgb;

  // handshakes
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_acc    = start & ~busy;

  // mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swap_mode_r <= SWAP_NONE;
    end else if (cfg_valid && cfg_ready) begin
      swap_mode_r <= cfg_data;
    end
  end

  // centering and products
  ycs_mult #(
    .FRAC_BITS(FRAC_BITS),
    .PROD_W   (PROD_W)
  ) u_mult (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (in_acc),
    .in_beat(in_data),
    .out_vld(mult_vld),
    .ys     (ys),
    .prod_r (prod_r),
    .prod_gb(prod_gb),
    .prod_gr(prod_gr),
    .prod_b (prod_b)
  );

  // sums and saturation
  ycs_sum_clamp #(
    .FRAC_BITS(FRAC_BITS),
    .PROD_W   (PROD_W)
  ) u_sum_clamp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (mult_vld),
    .ys     (ys),
    .prod_r (prod_r),
    .prod_gb(prod_gb),
    .prod_gr(prod_gr),
    .prod_b (prod_b),
    .out_vld(clamp_vld),
    .rgb    (rgb)
  );

  // channel routing and output register
  ycs_swap u_swap (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (clamp_vld),
    .rgb      (rgb),
    .swap_mode(swap_mode_r),
    .out_vld  (out_valid),
    .out_beat (out_data)
  );

  // a result only ever follows an earlier accepted input beat
  a_out_follows_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_acc, 5))
    else $error("result without matching input beat");

  // every beat taken yields a result at the output
  a_in_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##5 out_valid)
    else $error("input beat lost in pipeline");

  // neutral chroma gives gray equal to luma in every routing
  a_gray_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.chroma_blue == 8'd128 && in_data.chroma_red == 8'd128)
    |-> ##5 (out_data.red_out == out_data.green_out &&
             out_data.green_out == out_data.blue_out &&
             out_data.red_out == $past(in_data.luma, 5)))
    else $error("neutral chroma not converted to gray");

endmodule
